// ===== src/corexy_move_step_sequencer_assert.svh =====
// Assertion macros used by the checker of the move step sequencer
`ifndef COREXY_MOVE_STEP_SEQUENCER_ASSERT_SVH
`define COREXY_MOVE_STEP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high
`define CXMS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high
`define CXMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cxms_pkg.sv =====
// Shared types and constants of the move step sequencer
package cxms_pkg;

   localparam int CXMS_MM_W        = 12;
   localparam int CXMS_POS_W       = 16;
   localparam int CXMS_STEPS_W     = 15;
   localparam int CXMS_TICK_W      = 8;
   localparam int CXMS_CSR_W       = 8;
   localparam int CXMS_CSR_INDEX_W = 2;
   localparam int CXMS_QUEUE_DEPTH = 4;

   // floor(m / 9) as (m * 3641) >> 15, exact for 12-bit magnitudes
   localparam logic [CXMS_MM_W-1:0] CXMS_RECIP_NINE  = 12'd3641;
   localparam int                   CXMS_RECIP_SHIFT = 15;
   localparam int                   CXMS_QUO_W       = 9;

   // Register reset values
   localparam logic [CXMS_CSR_W-1:0] CXMS_GAP_RESET    = 8'd5;
   localparam logic [CXMS_CSR_W-1:0] CXMS_SETTLE_RESET = 8'd1;
   localparam logic [CXMS_CSR_W-1:0] CXMS_HIGH_RESET   = 8'd1;
   localparam logic [CXMS_CSR_W-1:0] CXMS_LOW_RESET    = 8'd1;

   typedef enum logic [CXMS_CSR_INDEX_W-1:0] {
      CSR_STEP_GAP,
      CSR_ENABLE_SETTLE,
      CSR_PULSE_HIGH,
      CSR_PULSE_LOW
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETTLE,
      PH_HIGH,
      PH_LOW,
      PH_GAP,
      PH_SEGEND
   } phase_type;

   typedef enum logic {
      ACT_TICK,
      ACT_MOVE
   } action_type;

   typedef struct packed {
      logic [CXMS_CSR_W-1:0] step_gap;
      logic [CXMS_CSR_W-1:0] settle;
      logic [CXMS_CSR_W-1:0] pulse_high;
      logic [CXMS_CSR_W-1:0] pulse_low;
   } csr_type;

   typedef struct packed {
      action_type                   action;
      logic signed [CXMS_POS_W-1:0] x_steps;
      logic signed [CXMS_POS_W-1:0] y_steps;
   } cmd_type;

   typedef struct packed {
      logic enable_n;
      logic dir_a;
      logic dir_b;
      logic step_a;
      logic step_b;
      logic busy_res;
      logic rejected;
   } rsp_type;

endpackage

// ===== src/cxms_fifo.sv =====
// Small register queue used between the front, the back and the result port
module cxms_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload on transfer
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/cxms_front.sv =====
// Front end: accepts items and converts millimetre targets to step counts
module cxms_front import cxms_pkg::*; (
   input  logic                        push,
   input  logic                        queue_full,
   input  logic                        action,
   input  logic signed [CXMS_MM_W-1:0] target_x_mm,
   input  logic signed [CXMS_MM_W-1:0] target_y_mm,
   output logic                        cmd_push,
   output cmd_type                     cmd
);

   // floor(40 * r / 9) for a remainder r below nine
   function automatic logic [5:0] frac_steps(input logic [3:0] rem);
      logic [5:0] val;
      case (rem)
         4'd0:    val = 6'd0;
         4'd1:    val = 6'd4;
         4'd2:    val = 6'd8;
         4'd3:    val = 6'd13;
         4'd4:    val = 6'd17;
         4'd5:    val = 6'd22;
         4'd6:    val = 6'd26;
         4'd7:    val = 6'd31;
         4'd8:    val = 6'd35;
         default: val = 6'd0;
      endcase
      return val;
   endfunction

   // Steps = floor(40*|mm|/9), one less on a nonzero multiple of nine, signed
   function automatic logic signed [CXMS_POS_W-1:0] mm_to_steps(
      input logic signed [CXMS_MM_W-1:0] mm
   );
      logic [CXMS_MM_W-1:0]   mag;
      logic [2*CXMS_MM_W-1:0] prod;
      logic [CXMS_QUO_W-1:0]  quo;
      logic [3:0]             rem;
      logic [CXMS_POS_W-1:0]  q;
      mag  = mm[CXMS_MM_W-1] ? (~mm + 1'b1) : mm;
      prod = mag * CXMS_RECIP_NINE;
      quo  = CXMS_QUO_W'(prod >> CXMS_RECIP_SHIFT);
      rem  = 4'(mag - CXMS_MM_W'(CXMS_MM_W'(quo) * CXMS_MM_W'(9)));
      q    = CXMS_POS_W'(quo) * CXMS_POS_W'(40) + CXMS_POS_W'(frac_steps(rem))
             - CXMS_POS_W'((mag != '0) && (rem == '0));
      return mm[CXMS_MM_W-1] ? -q : q;
   endfunction

   // Classify and convert on transfer into the command queue
   assign cmd_push    = push && !queue_full;
   assign cmd.action  = action_type'(action);
   assign cmd.x_steps = mm_to_steps(target_x_mm);
   assign cmd.y_steps = mm_to_steps(target_y_mm);

endmodule

// ===== src/cxms_back.sv =====
// Back end: segment and step-pulse sequencer, one queued item per cycle while the result queue has room
module cxms_back import cxms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp
);

   logic signed [CXMS_POS_W-1:0] pos_x_ff, pos_x_in;
   logic signed [CXMS_POS_W-1:0] pos_y_ff, pos_y_in;
   logic signed [CXMS_POS_W-1:0] pend_x_ff, pend_x_in;
   phase_type                    phase_ff, phase_in;
   logic                         on_x_ff, on_x_in;
   logic [CXMS_STEPS_W-1:0]      steps_left_ff, steps_left_in;
   logic [CXMS_TICK_W-1:0]       tick_ff, tick_in, tick_inc;
   logic                         en_ff, en_in;
   logic                         da_ff, da_in, db_ff, db_in;
   logic                         sa_ff, sa_in, sb_ff, sb_in;
   logic                         seg_da_ff, seg_da_in, seg_db_ff, seg_db_in;
   logic [CXMS_TICK_W-1:0]       hi_len, lo_len;
   logic [CXMS_STEPS_W:0]        span_y, span_x;
   logic                         do_start, do_sof, rejected;

   // Direction flag on top, step count below
   function automatic logic [CXMS_STEPS_W:0] seg_span(
      input logic signed [CXMS_POS_W-1:0] from_pos,
      input logic signed [CXMS_POS_W-1:0] to_pos
   );
      logic signed [CXMS_POS_W:0] diff;
      logic                       up;
      logic [CXMS_POS_W:0]        mag;
      diff = {to_pos[CXMS_POS_W-1], to_pos} - {from_pos[CXMS_POS_W-1], from_pos};
      up   = diff > 0;
      mag  = up ? diff : -diff;
      return {up, mag[CXMS_STEPS_W-1:0]};
   endfunction

   assign cmd_pop  = cmd_valid && !rsp_full;
   assign rsp_push = cmd_pop;
   assign hi_len   = (csr.pulse_high == '0) ? CXMS_TICK_W'(1) : csr.pulse_high;
   assign lo_len   = (csr.pulse_low == '0) ? CXMS_TICK_W'(1) : csr.pulse_low;
   assign tick_inc = (tick_ff == '1) ? tick_ff : tick_ff + 1'b1;

   // Apply one item: start a move, reject it, or advance time by one tick
   always_comb begin
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      pend_x_in     = pend_x_ff;
      phase_in      = phase_ff;
      on_x_in       = on_x_ff;
      steps_left_in = steps_left_ff;
      tick_in       = tick_ff;
      en_in         = en_ff;
      da_in         = da_ff;
      db_in         = db_ff;
      sa_in         = sa_ff;
      sb_in         = sb_ff;
      seg_da_in     = seg_da_ff;
      seg_db_in     = seg_db_ff;
      span_y        = '0;
      span_x        = '0;
      do_start      = 1'b0;
      do_sof        = 1'b0;
      rejected      = 1'b0;
      if (cmd_pop) begin
         if (cmd.action == ACT_MOVE) begin
            if (phase_ff != PH_IDLE) begin
               rejected = 1'b1;
            end else begin
               // Y segment first, motors opposite
               span_y        = seg_span(pos_y_ff, cmd.y_steps);
               pend_x_in     = cmd.x_steps;
               on_x_in       = 1'b0;
               steps_left_in = span_y[CXMS_STEPS_W-1:0];
               seg_da_in     = span_y[CXMS_STEPS_W];
               seg_db_in     = !span_y[CXMS_STEPS_W];
               pos_y_in      = cmd.y_steps;
               do_start      = 1'b1;
            end
         end else if (phase_ff == PH_SEGEND) begin
            do_start = 1'b1;
         end else begin
            case (phase_ff)
               PH_SETTLE: begin
                  if (tick_inc >= csr.settle) do_sof = 1'b1;
                  else tick_in = tick_inc;
               end
               PH_GAP: begin
                  if (tick_inc >= csr.step_gap) do_sof = 1'b1;
                  else tick_in = tick_inc;
               end
               PH_HIGH: begin
                  if (tick_inc >= hi_len) begin
                     sa_in    = 1'b0;
                     sb_in    = 1'b0;
                     phase_in = PH_LOW;
                     tick_in  = '0;
                  end else begin
                     tick_in = tick_inc;
                  end
               end
               PH_LOW: begin
                  if (tick_inc >= lo_len) begin
                     phase_in = PH_GAP;
                     tick_in  = '0;
                     if (csr.step_gap == '0) do_sof = 1'b1;
                  end else begin
                     tick_in = tick_inc;
                  end
               end
               default: begin
               end
            endcase
         end

         // Enable the motors and begin the settle wait
         if (do_start) begin
            en_in    = 1'b0;
            phase_in = PH_SETTLE;
            tick_in  = '0;
            if (csr.settle == '0) do_sof = 1'b1;
         end

         // Issue the next step or close the segment
         if (do_sof) begin
            tick_in = '0;
            if (steps_left_in == '0) begin
               en_in = 1'b1;
               if (!on_x_in) begin
                  span_x        = seg_span(pos_x_ff, pend_x_in);
                  on_x_in       = 1'b1;
                  steps_left_in = span_x[CXMS_STEPS_W-1:0];
                  seg_da_in     = span_x[CXMS_STEPS_W];
                  seg_db_in     = span_x[CXMS_STEPS_W];
                  pos_x_in      = pend_x_in;
                  phase_in      = PH_SEGEND;
               end else begin
                  phase_in = PH_IDLE;
               end
            end else begin
               steps_left_in = steps_left_in - 1'b1;
               da_in         = seg_da_in;
               db_in         = seg_db_in;
               sa_in         = 1'b1;
               sb_in         = 1'b1;
               phase_in      = PH_HIGH;
            end
         end
      end
   end

   // Result of this item
   assign rsp.enable_n = en_in;
   assign rsp.dir_a    = da_in;
   assign rsp.dir_b    = db_in;
   assign rsp.step_a   = sa_in;
   assign rsp.step_b   = sb_in;
   assign rsp.busy_res = (phase_in != PH_IDLE);
   assign rsp.rejected = rejected;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         pend_x_ff     <= '0;
         phase_ff      <= PH_IDLE;
         on_x_ff       <= 1'b0;
         steps_left_ff <= '0;
         tick_ff       <= '0;
         en_ff         <= 1'b1;
         da_ff         <= 1'b0;
         db_ff         <= 1'b0;
         sa_ff         <= 1'b0;
         sb_ff         <= 1'b0;
         seg_da_ff     <= 1'b0;
         seg_db_ff     <= 1'b0;
      end else begin
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         pend_x_ff     <= pend_x_in;
         phase_ff      <= phase_in;
         on_x_ff       <= on_x_in;
         steps_left_ff <= steps_left_in;
         tick_ff       <= tick_in;
         en_ff         <= en_in;
         da_ff         <= da_in;
         db_ff         <= db_in;
         sa_ff         <= sa_in;
         sb_ff         <= sb_in;
         seg_da_ff     <= seg_da_in;
         seg_db_ff     <= seg_db_in;
      end
   end

endmodule

// ===== src/corexy_move_step_sequencer.sv =====
// Top level of the CoreXY move step sequencer
//
//   channel   handshake          payload
//   request   push / full        req_action, req_target_x_mm, req_target_y_mm
//   result    pop / empty        rsp_enable_n .. rsp_rejected (7 bits)
//   csr       valid / ready      csr_index, csr_data (ready is always high)
//
// One item per clock sustained while the result queue has room; the rate is set
// by the back end, which works out the whole sequencer state for one item
// combinationally. A request is held in the command queue and its result in
// the result queue. Reset (synchronous) empties both queues
// and loads the register defaults. A full result queue stalls the back end;
// the command queue keeps taking items until it is full in turn.
module corexy_move_step_sequencer import cxms_pkg::*; #(
   parameter int QUEUE_DEPTH = CXMS_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_action,
   input  logic signed [CXMS_MM_W-1:0]        req_target_x_mm,
   input  logic signed [CXMS_MM_W-1:0]        req_target_y_mm,
   output logic                               empty,
   input  logic                               pop,
   output logic                               rsp_enable_n,
   output logic                               rsp_dir_a,
   output logic                               rsp_dir_b,
   output logic                               rsp_step_a,
   output logic                               rsp_step_b,
   output logic                               rsp_busy_res,
   output logic                               rsp_rejected,
   input  logic                               valid,
   output logic                               ready,
   input  logic [CXMS_CSR_INDEX_W-1:0]        csr_index,
   input  logic [CXMS_CSR_W-1:0]              csr_data
);

   csr_type csr_ff;
   cmd_type cmd_in, cmd_out;
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   rsp_type rsp_in, rsp_out;
   logic    rsp_push, rsp_full;

   // Register writes
   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.step_gap   <= CXMS_GAP_RESET;
         csr_ff.settle     <= CXMS_SETTLE_RESET;
         csr_ff.pulse_high <= CXMS_HIGH_RESET;
         csr_ff.pulse_low  <= CXMS_LOW_RESET;
      end else if (valid && ready) begin
         case (csr_index_type'(csr_index))
            CSR_STEP_GAP:      csr_ff.step_gap   <= csr_data;
            CSR_ENABLE_SETTLE: csr_ff.settle     <= csr_data;
            CSR_PULSE_HIGH:    csr_ff.pulse_high <= csr_data;
            CSR_PULSE_LOW:     csr_ff.pulse_low  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   cxms_front u_front (
      .push        (push),
      .queue_full  (cmd_full),
      .action      (req_action),
      .target_x_mm (req_target_x_mm),
      .target_y_mm (req_target_y_mm),
      .cmd_push    (cmd_push),
      .cmd         (cmd_in)
   );

   assign full = cmd_full;

   cxms_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   cxms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_out),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );

   cxms_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_out),
      .empty     (empty)
   );

   assign rsp_enable_n = rsp_out.enable_n;
   assign rsp_dir_a    = rsp_out.dir_a;
   assign rsp_dir_b    = rsp_out.dir_b;
   assign rsp_step_a   = rsp_out.step_a;
   assign rsp_step_b   = rsp_out.step_b;
   assign rsp_busy_res = rsp_out.busy_res;
   assign rsp_rejected = rsp_out.rejected;

endmodule

// ===== src/cxms_checker.sv =====
// Port-level checker of the move step sequencer and its bind
`include "corexy_move_step_sequencer_assert.svh"

module cxms_checker import cxms_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        full,
   input logic                        empty,
   input logic                        pop,
   input logic                        rsp_enable_n,
   input logic                        rsp_dir_a,
   input logic                        rsp_dir_b,
   input logic                        rsp_step_a,
   input logic                        rsp_step_b,
   input logic                        rsp_busy_res,
   input logic                        rsp_rejected
);

   logic [6:0] rsp_bits;

   // Gather the result fields for the hold check
   assign rsp_bits = {rsp_enable_n, rsp_dir_a, rsp_dir_b, rsp_step_a, rsp_step_b,
                      rsp_busy_res, rsp_rejected};

   // Reset leaves no result and room for input
   `CXMS_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, empty && !full, "queues not clear after reset")

   // A waiting result holds until it is taken
   `CXMS_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_bits), "result changed while stalled")

   // Idle means motors released and no pulse
   `CXMS_ASSERT_IMPLY(a_idle_pins, clock, reset, !empty && !rsp_busy_res, rsp_enable_n && !rsp_step_a && !rsp_step_b, "pins active while idle")

   // A rejected move only happens while busy
   `CXMS_ASSERT_IMPLY(a_reject_busy, clock, reset, !empty && rsp_rejected, rsp_busy_res, "rejection while idle")

   // Both motors pulse together and only while enabled
   `CXMS_ASSERT_IMPLY(a_step_pair, clock, reset, !empty && (rsp_step_a || rsp_step_b), rsp_step_a && rsp_step_b && !rsp_enable_n, "step pins out of step")

endmodule

bind corexy_move_step_sequencer cxms_checker u_cxms_checker (.*);

// ===== test/corexy_move_step_checker.sv =====
// Pin-level predictor and result checker for the CoreXY move step sequencer
`timescale 1ns / 1ps

module corexy_move_step_checker import cxms_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          full,
   input  logic                          req_action,
   input  logic signed [CXMS_MM_W-1:0]   req_target_x_mm,
   input  logic signed [CXMS_MM_W-1:0]   req_target_y_mm,
   input  logic                          empty,
   input  logic                          pop,
   input  logic                          rsp_enable_n,
   input  logic                          rsp_dir_a,
   input  logic                          rsp_dir_b,
   input  logic                          rsp_step_a,
   input  logic                          rsp_step_b,
   input  logic                          rsp_busy_res,
   input  logic                          rsp_rejected,
   input  logic                          valid,
   input  logic                          ready,
   input  logic [CXMS_CSR_INDEX_W-1:0]   csr_index,
   input  logic [CXMS_CSR_W-1:0]         csr_data,
   output int                            fail_count,
   output int                            pending_count
);

   // Keep the log bounded when the design is badly broken
   localparam int MAX_REPORTS = 200;

   // Timing registers as last written
   logic [CXMS_CSR_W-1:0]        gap_ticks;
   logic [CXMS_CSR_W-1:0]        settle_ticks;
   logic [CXMS_CSR_W-1:0]        high_ticks;
   logic [CXMS_CSR_W-1:0]        low_ticks;

   // Motion state
   logic signed [CXMS_POS_W-1:0] pos_x;
   logic signed [CXMS_POS_W-1:0] pos_y;
   logic signed [CXMS_POS_W-1:0] pend_x;
   phase_type                    seq_phase;
   logic                         on_x;
   logic [CXMS_STEPS_W-1:0]      steps_left;
   logic [CXMS_TICK_W-1:0]       tick_cnt;
   logic                         pin_en, pin_da, pin_db, pin_sa, pin_sb;
   logic                         seg_da, seg_db;

   rsp_type                      expected_pins_q[$];
   int                           n_err = 0;

   // Truncated mm to step conversion; exact multiples of 9 lose one step
   function automatic int mm_to_steps(input logic signed [CXMS_MM_W-1:0] mm);
      int mag;
      int q;
      mag = (mm < 0) ? -int'(mm) : int'(mm);
      q = (40 * mag) / 9;
      if (mag != 0 && mag % 9 == 0)
         q = q - 1;
      return (mm < 0) ? -q : q;
   endfunction

   // Length of the current timed phase; zero pulse widths count as one
   function automatic int phase_ticks();
      case (seq_phase)
         PH_SETTLE: return int'(settle_ticks);
         PH_HIGH:   return (high_ticks == 0) ? 1 : int'(high_ticks);
         PH_LOW:    return (low_ticks == 0) ? 1 : int'(low_ticks);
         PH_GAP:    return int'(gap_ticks);
         default:   return 0;
      endcase
   endfunction

   task automatic load_segment(input int from_steps, input int to_steps, input logic x_axis);
      int   delta;
      logic up;
      delta = to_steps - from_steps;
      up = (delta > 0);
      steps_left = CXMS_STEPS_W'(up ? delta : -delta);
      seg_da = up;
      seg_db = x_axis ? up : ~up;
   endtask

   // Release enable; after Y, queue the X segment for the next tick
   task automatic close_segment();
      pin_en = 1'b1;
      if (!on_x) begin
         on_x = 1'b1;
         load_segment(pos_x, pend_x, 1'b1);
         pos_x = pend_x;
         seq_phase = PH_SEGEND;
      end else begin
         seq_phase = PH_IDLE;
      end
      tick_cnt = '0;
   endtask

   // Walk through every phase whose time has elapsed
   task automatic run_phases();
      bit go;
      go = 1'b1;
      while (go) begin
         if (seq_phase == PH_IDLE || seq_phase == PH_SEGEND) begin
            go = 1'b0;
         end else if (int'(tick_cnt) < phase_ticks()) begin
            go = 1'b0;
         end else begin
            tick_cnt = '0;
            case (seq_phase)
               PH_SETTLE, PH_GAP: begin
                  if (steps_left == 0) begin
                     close_segment();
                     go = 1'b0;
                  end else begin
                     steps_left = steps_left - 1'b1;
                     pin_da = seg_da;
                     pin_db = seg_db;
                     pin_sa = 1'b1;
                     pin_sb = 1'b1;
                     seq_phase = PH_HIGH;
                  end
               end
               PH_HIGH: begin
                  pin_sa = 1'b0;
                  pin_sb = 1'b0;
                  seq_phase = PH_LOW;
               end
               default: seq_phase = PH_GAP;
            endcase
         end
      end
   endtask

   task automatic open_segment();
      pin_en = 1'b0;
      seq_phase = PH_SETTLE;
      tick_cnt = '0;
      run_phases();
   endtask

   // Advance the sequencer by one item and return the pin levels it leaves
   task automatic step_sequence(input action_type act,
                                input logic signed [CXMS_MM_W-1:0] x_mm,
                                input logic signed [CXMS_MM_W-1:0] y_mm,
                                output rsp_type pins);
      int y_steps;
      pins.rejected = 1'b0;
      if (act == ACT_MOVE) begin
         if (seq_phase != PH_IDLE) begin
            pins.rejected = 1'b1;
         end else begin
            y_steps = mm_to_steps(y_mm);
            pend_x = CXMS_POS_W'(mm_to_steps(x_mm));
            on_x = 1'b0;
            load_segment(pos_y, y_steps, 1'b0);
            pos_y = CXMS_POS_W'(y_steps);
            open_segment();
         end
      end else if (seq_phase == PH_SEGEND) begin
         open_segment();
      end else if (seq_phase != PH_IDLE) begin
         if (tick_cnt < 8'hFF)
            tick_cnt = tick_cnt + 1'b1;
         run_phases();
      end
      pins.enable_n = pin_en;
      pins.dir_a    = pin_da;
      pins.dir_b    = pin_db;
      pins.step_a   = pin_sa;
      pins.step_b   = pin_sb;
      pins.busy_res = (seq_phase != PH_IDLE);
   endtask

   task automatic compare_pin(input string name, input logic want, input logic seen);
      if (seen !== want) begin
         n_err++;
         if (n_err <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, seen);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         gap_ticks    = CXMS_GAP_RESET;
         settle_ticks = CXMS_SETTLE_RESET;
         high_ticks   = CXMS_HIGH_RESET;
         low_ticks    = CXMS_LOW_RESET;
         pos_x        = '0;
         pos_y        = '0;
         pend_x       = '0;
         seq_phase    = PH_IDLE;
         on_x         = 1'b0;
         steps_left   = '0;
         tick_cnt     = '0;
         pin_en       = 1'b1;
         {pin_da, pin_db, pin_sa, pin_sb, seg_da, seg_db} = '0;
         expected_pins_q.delete();
         n_err = 0;
      end else begin
         // Apply a register transfer
         if (valid && ready) begin
            case (csr_index_type'(csr_index))
               CSR_STEP_GAP:      gap_ticks    = csr_data;
               CSR_ENABLE_SETTLE: settle_ticks = csr_data;
               CSR_PULSE_HIGH:    high_ticks   = csr_data;
               CSR_PULSE_LOW:     low_ticks    = csr_data;
               default: ;
            endcase
         end

         // Compare a result transfer against the oldest prediction
         if (pop && !empty) begin
            seen = {rsp_enable_n, rsp_dir_a, rsp_dir_b, rsp_step_a, rsp_step_b,
                    rsp_busy_res, rsp_rejected};
            if (expected_pins_q.size() == 0) begin
               n_err++;
               if (n_err <= MAX_REPORTS)
                  $display("%0t: unexpected result, expected none, actual %b", $time, seen);
            end else begin
               want = expected_pins_q.pop_front();
               compare_pin("enable_n", want.enable_n, seen.enable_n);
               compare_pin("dir_a",    want.dir_a,    seen.dir_a);
               compare_pin("dir_b",    want.dir_b,    seen.dir_b);
               compare_pin("step_a",   want.step_a,   seen.step_a);
               compare_pin("step_b",   want.step_b,   seen.step_b);
               compare_pin("busy_res", want.busy_res, seen.busy_res);
               compare_pin("rejected", want.rejected, seen.rejected);
            end
         end

         // Predict the result of a request transfer
         if (push && !full) begin
            step_sequence(action_type'(req_action), req_target_x_mm, req_target_y_mm, want);
            expected_pins_q.push_back(want);
         end
      end
      fail_count    <= n_err;
      pending_count <= expected_pins_q.size();
   end

endmodule

// ===== test/corexy_move_step_sequencer_tb.sv =====
// Stimulus and verdict for the CoreXY move step sequencer regression
`timescale 1ns / 1ps

module corexy_move_step_sequencer_tb;
   import cxms_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 450;
   localparam int MAX_IDLE     = 13;
   localparam int MM_MAX       = 2**(CXMS_MM_W-1) - 1;
   localparam int MM_MIN       = -(2**(CXMS_MM_W-1));

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         push = 1'b0;
   logic                         full;
   logic                         req_action = 1'b0;
   logic signed [CXMS_MM_W-1:0]  req_target_x_mm = '0;
   logic signed [CXMS_MM_W-1:0]  req_target_y_mm = '0;
   logic                         empty;
   logic                         pop = 1'b0;
   logic                         rsp_enable_n;
   logic                         rsp_dir_a;
   logic                         rsp_dir_b;
   logic                         rsp_step_a;
   logic                         rsp_step_b;
   logic                         rsp_busy_res;
   logic                         rsp_rejected;
   logic                         valid = 1'b0;
   logic                         ready;
   logic [CXMS_CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CXMS_CSR_W-1:0]        csr_data = '0;

   int                           fail_count;
   int                           pending_count;
   int                           cycle_count = 0;
   int                           n_pushed = 0;
   int                           n_popped = 0;
   int                           last_idle_idx = -1;
   int                           pop_hold = 0;
   bit                           tx_calm = 1'b0;
   logic                         rx_calm = 1'b0;
   int                           cur_x_mm = 0;
   int                           cur_y_mm = 0;

   corexy_move_step_sequencer u_dut (.*);

   corexy_move_step_checker u_checker (.*);

   always #10 clock = ~clock;

   // Hard stop for a hung run
   always @(posedge clock) begin
      if (cycle_count == CYCLE_LIMIT) begin
         $display("corexy_move_step_sequencer regression: fail");
         $finish;
      end else begin
         cycle_count <= cycle_count + 1;
      end
   end

   // Result side: random stalls, and track the latest result seen idle
   always @(posedge clock) begin : result_drain
      int stall;
      if (reset) begin
         pop      <= 1'b0;
         pop_hold <= 0;
      end else if (pop && !empty) begin
         n_popped <= n_popped + 1;
         if (!rsp_busy_res)
            last_idle_idx <= n_popped;
         stall = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
         pop      <= (stall == 0);
         pop_hold <= (stall == 0) ? 0 : stall - 1;
      end else if (!pop) begin
         if (pop_hold == 0)
            pop <= 1'b1;
         else
            pop_hold <= pop_hold - 1;
      end
   end

   function automatic logic signed [CXMS_MM_W-1:0] clamp_mm(input int v);
      if (v > MM_MAX)
         return CXMS_MM_W'(MM_MAX);
      if (v < MM_MIN)
         return CXMS_MM_W'(MM_MIN);
      return CXMS_MM_W'(v);
   endfunction

   // Mostly short timings, now and then a longer one
   function automatic logic [CXMS_CSR_W-1:0] pick_ticks();
      return ($urandom_range(0, 4) == 0) ? CXMS_CSR_W'($urandom_range(0, 12))
                                         : CXMS_CSR_W'($urandom_range(0, 3));
   endfunction

   // Hold push until the transfer completes
   task automatic send_item(input action_type act,
                            input logic signed [CXMS_MM_W-1:0] x_mm,
                            input logic signed [CXMS_MM_W-1:0] y_mm);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push            <= 1'b1;
      req_action      <= act;
      req_target_x_mm <= x_mm;
      req_target_y_mm <= y_mm;
      do @(posedge clock); while (full);
      n_pushed++;
   endtask

   // Feed ticks, and now and then a move, until a result after the given move shows the block idle
   task automatic tick_until_idle(input int move_idx);
      while (last_idle_idx < move_idx) begin
         if ($urandom_range(0, 15) == 0)
            send_item(ACT_MOVE, clamp_mm(cur_x_mm + int'($urandom_range(0, 6)) - 3),
                      clamp_mm(cur_y_mm + int'($urandom_range(0, 6)) - 3));
         else
            send_item(ACT_TICK, CXMS_MM_W'($urandom), CXMS_MM_W'($urandom));
      end
   endtask

   task automatic travel_to(input int x_mm, input int y_mm);
      int idx;
      idx = n_pushed;
      send_item(ACT_MOVE, clamp_mm(x_mm), clamp_mm(y_mm));
      cur_x_mm = int'(clamp_mm(x_mm));
      cur_y_mm = int'(clamp_mm(y_mm));
      tick_until_idle(idx);
   endtask

   // Stop sending and hold until every result has been taken
   task automatic wait_drained();
      push <= 1'b0;
      while (n_popped != n_pushed) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CXMS_CSR_W-1:0] value);
      valid     <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!ready);
   endtask

   // Write all registers, or a random subset of them
   task automatic program_timing(input logic [CXMS_CSR_W-1:0] gap, settle, high, low,
                                 input bit all);
      if (all || $urandom_range(0, 1)) write_csr(CSR_STEP_GAP, gap);
      if (all || $urandom_range(0, 1)) write_csr(CSR_ENABLE_SETTLE, settle);
      if (all || $urandom_range(0, 1)) write_csr(CSR_PULSE_HIGH, high);
      if (all || $urandom_range(0, 1)) write_csr(CSR_PULSE_LOW, low);
      valid <= 1'b0;
   endtask

   initial begin : stimulus
      int move_idx;
      int n_start;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Tick while idle, then a short move with full-range moves rejected while busy
      send_item(ACT_TICK, '0, '0);
      move_idx = n_pushed;
      send_item(ACT_MOVE, clamp_mm(1), clamp_mm(-1));
      send_item(ACT_MOVE, clamp_mm(MM_MAX), clamp_mm(MM_MIN));
      send_item(ACT_MOVE, clamp_mm(MM_MIN), clamp_mm(MM_MAX));
      cur_x_mm = 1;
      cur_y_mm = -1;
      tick_until_idle(move_idx);

      // Zero-length segments
      travel_to(1, -1);

      // Zero settle, gap and pulse widths on a move to multiples of 9
      wait_drained();
      program_timing('0, '0, '0, '0, 1'b1);
      travel_to(9, -9);

      // Short trip with no idling on either side
      tx_calm = 1'b1;
      rx_calm <= 1'b1;
      travel_to(5, -5);
      tx_calm = 1'b0;
      rx_calm <= 1'b0;

      // Random timing phases with short random moves
      n_start = n_pushed;
      while (n_pushed - n_start < RANDOM_ITEMS) begin
         wait_drained();
         program_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), 1'b0);
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm <= ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 4)) begin
            travel_to(cur_x_mm + int'($urandom_range(0, 4)) - 2,
                      cur_y_mm + int'($urandom_range(0, 4)) - 2);
            repeat ($urandom_range(0, 2))
               send_item(ACT_TICK, CXMS_MM_W'($urandom), CXMS_MM_W'($urandom));
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("corexy_move_step_sequencer regression: pass");
      else
         $display("corexy_move_step_sequencer regression: fail");
      $finish;
   end

endmodule
